// ===== hdl/unique_track_pair_matcher_macros.svh =====
// assertion macros for the unique track pair matcher
// included by the top level, no other dependencies
`ifndef UNIQUE_TRACK_PAIR_MATCHER_MACROS_SVH
`define UNIQUE_TRACK_PAIR_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define UTPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define UTPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next cycle check failed");
`else
`define UTPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define UTPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/utpm_pkg.sv =====
// shared constants, types and register codes of the track pair matcher
// no dependencies
package utpm_pkg;

   localparam int ROW_W      = 3;
   localparam int COL_W      = 3;
   localparam int MAX_ROWS   = 1 << ROW_W;
   localparam int MAX_COLS   = 1 << COL_W;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int CNT_W      = 4;
   localparam int PULL_W     = 16;
   localparam int MOM_W      = 16;
   localparam int CFG_PULL_W = 15;
   localparam int LIMIT_W    = 17;
   localparam int MINMOM_W   = 32;
   localparam int STORE_W    = PULL_W + MOM_W + 2;
   localparam int OUT_LIMIT  = 64;
   localparam int RES_CNT_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PULL_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULL_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULL_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOM_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOM_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CONS_MODE  = 3'd5;

   typedef struct packed {
      logic              load;
      logic              start;
      logic              advance;
      logic              cons_set;
      logic              build_rd;
      logic              take;
      logic              take_cons;
      logic              emit;
      logic              quality;
      logic              flush;
      logic              clear_marks;
      logic [ADDR_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic             cell_pass;
      logic             cell_unique;
      logic             below_end;
      logic             cons_mode;
      logic             out_free;
      logic             held_valid;
      logic [CNT_W-1:0] max_match;
   } sts_type;

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [PULL_W-1:0] pull;
      logic [MOM_W-1:0]         mom;
      logic                     quality;
      logic                     is_pair;
      logic                     last;
   } result_type;

endpackage

// ===== hdl/utpm_ifs.sv =====
// request and response channel interfaces of the track pair matcher
// no dependencies
interface utpm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         row_index;
   logic [2:0]         col_index;
   logic signed [15:0] pull_value;
   logic [15:0]        momentum_value;
   logic               cluster_ok;
   logic               overlap_seen;
   logic [3:0]         rows_in_use;
   logic [3:0]         cols_in_use;
   logic               last_item;
   modport source (output valid, row_index, col_index, pull_value, momentum_value,
                   cluster_ok, overlap_seen, rows_in_use, cols_in_use, last_item,
                   input ready);
   modport sink (input valid, row_index, col_index, pull_value, momentum_value,
                 cluster_ok, overlap_seen, rows_in_use, cols_in_use, last_item,
                 output ready);
endinterface

interface utpm_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         match_row;
   logic [2:0]         match_col;
   logic signed [15:0] match_pull;
   logic [15:0]        match_momentum;
   logic               quality;
   logic               is_pair;
   logic               last_result;
   modport source (output valid, match_row, match_col, match_pull, match_momentum,
                   quality, is_pair, last_result, input ready);
   modport sink (input valid, match_row, match_col, match_pull, match_momentum,
                 quality, is_pair, last_result, output ready);
endinterface

// ===== hdl/utpm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module utpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/utpm_ctrl.sv =====
// sequencer of the track pair matcher: rounds, map builds, scans, emission
// depends on utpm_pkg
module utpm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  utpm_pkg::sts_type sts,
   output utpm_pkg::cmd_type cmd
);
   import utpm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_CHECK   = 8'b00000010,
      ST_BUILD   = 8'b00000100,
      ST_DRAIN   = 8'b00001000,
      ST_SCAN    = 8'b00010000,
      ST_READ    = 8'b00100000,
      ST_EMIT    = 8'b01000000,
      ST_FINISH  = 8'b10000000
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]       found_ff, found_in;
   logic [RES_CNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                   cons_ff, cons_in;
   logic                   adv_ff, adv_in;
   logic                   go_next;
   logic [CNT_W-1:0]       found_eff;

   always_comb begin
      cmd        = '0;
      cmd.idx    = idx_ff;
      cmd.quality = !cons_ff;
      req_ready  = 1'b0;
      state_in   = state_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      res_cnt_in = res_cnt_ff;
      cons_in    = cons_ff;
      adv_in     = 1'b0;
      go_next    = 1'b0;
      found_eff  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.start  = 1'b1;
                  res_cnt_in = '0;
                  cons_in    = 1'b0;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (adv_ff) begin
               cmd.advance = 1'b1;
            end else if (sts.below_end) begin
               if (sts.max_match != '0) begin
                  idx_in   = '0;
                  state_in = ST_BUILD;
               end else begin
                  adv_in = 1'b1;
               end
            end else if (sts.cons_mode) begin
               cmd.cons_set = 1'b1;
               cons_in      = 1'b1;
               idx_in       = '0;
               state_in     = ST_BUILD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_BUILD: begin
            cmd.build_rd = 1'b1;
            if (idx_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            idx_in   = '0;
            found_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.cell_pass && (cons_ff || sts.cell_unique)) begin
               cmd.take      = 1'b1;
               cmd.take_cons = cons_ff;
               found_in      = found_ff + CNT_W'(!cons_ff);
               if (res_cnt_ff < RES_CNT_W'(OUT_LIMIT)) begin
                  state_in = ST_READ;
               end else begin
                  go_next = 1'b1;
               end
            end else begin
               go_next = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!sts.held_valid || sts.out_free) begin
               cmd.emit   = 1'b1;
               res_cnt_in = res_cnt_ff + 1'b1;
               go_next    = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.flush       = 1'b1;
               cmd.clear_marks = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next cell or close the pass
      if (go_next) begin
         if (idx_ff != ADDR_W'(DEPTH - 1)) begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
         end else if (cons_ff) begin
            state_in = ST_FINISH;
         end else begin
            found_eff = (found_in >= sts.max_match) ? '0 : found_in;
            if (found_eff != '0) begin
               idx_in   = '0;
               state_in = ST_BUILD;
            end else begin
               adv_in   = 1'b1;
               state_in = ST_CHECK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         found_ff   <= '0;
         res_cnt_ff <= '0;
         cons_ff    <= 1'b0;
         adv_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
         res_cnt_ff <= res_cnt_in;
         cons_ff    <= cons_in;
         adv_ff     <= adv_in;
      end
   end
endmodule

// ===== hdl/utpm_dp.sv =====
// datapath of the track pair matcher: store, pass map, marks, limits, result regs
// depends on utpm_pkg and utpm_ram
module utpm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [utpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [utpm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [2:0]                    req_row,
   input  logic [2:0]                    req_col,
   input  logic signed [15:0]            req_pull,
   input  logic [15:0]                   req_mom,
   input  logic                          req_ok,
   input  logic                          req_ovl,
   input  logic [3:0]                    req_rows,
   input  logic [3:0]                    req_cols,
   input  utpm_pkg::cmd_type              cmd,
   output utpm_pkg::sts_type              sts,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output utpm_pkg::result_type           rsp_data
);
   import utpm_pkg::*;

   logic [CFG_PULL_W-1:0]       pull_start_ff, pull_start_in;
   logic [CFG_PULL_W-1:0]       pull_end_ff, pull_end_in;
   logic [CFG_PULL_W-1:0]       pull_step_ff, pull_step_in;
   logic [MOM_W-1:0]            mom_start_ff, mom_start_in;
   logic signed [MOM_W-1:0]     mom_step_ff, mom_step_in;
   logic                        cons_mode_ff, cons_mode_in;
   logic [CNT_W-1:0]            rows_ff, rows_in;
   logic [CNT_W-1:0]            cols_ff, cols_in;
   logic [LIMIT_W-1:0]          limit_ff, limit_in;
   logic signed [MINMOM_W-1:0]  minmom_ff, minmom_in;
   logic [MAX_ROWS-1:0][MAX_COLS-1:0] pm_ff, pm_in;
   logic [MAX_ROWS-1:0][MAX_COLS-1:0] marks_ff, marks_in;
   logic                        pend_ff, pend_in;
   logic [ADDR_W-1:0]           pend_addr_ff, pend_addr_in;
   result_type                  held_ff, held_in;
   logic                        held_valid_ff, held_valid_in;
   result_type                  out_ff, out_in;
   logic                        out_valid_ff, out_valid_in;

   logic [STORE_W-1:0]          rd_data;
   logic signed [PULL_W-1:0]    rd_pull;
   logic [MOM_W-1:0]            rd_mom;
   logic                        rd_ok, rd_ovl;
   logic [LIMIT_W-1:0]          abs_pull;
   logic [ROW_W-1:0]            pr, ci;
   logic [COL_W-1:0]            pc, cj;
   logic                        pass_bit;
   logic [MAX_ROWS-1:0]         row_other;
   logic                        uniq;
   logic [CFG_PULL_W-1:0]       step_eff;
   result_type                  new_res;

   utpm_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (cmd.load),
      .wr_addr({req_row, req_col}),
      .wr_data({req_pull, req_mom, req_ok, req_ovl}),
      .rd_addr(cmd.idx),
      .rd_data(rd_data)
   );

   assign rd_pull = rd_data[STORE_W-1 -: PULL_W];
   assign rd_mom  = rd_data[MOM_W+1:2];
   assign rd_ok   = rd_data[1];
   assign rd_ovl  = rd_data[0];
   assign pr      = pend_addr_ff[ADDR_W-1:COL_W];
   assign pc      = pend_addr_ff[COL_W-1:0];
   assign ci      = cmd.idx[ADDR_W-1:COL_W];
   assign cj      = cmd.idx[COL_W-1:0];

   always_comb begin
      abs_pull = rd_pull[PULL_W-1] ? (~{rd_pull[PULL_W-1], rd_pull} + LIMIT_W'(1))
                                   : {1'b0, rd_pull};
      pass_bit = ({1'b0, pr} < rows_ff) && ({1'b0, pc} < cols_ff) && !marks_ff[pr][pc] &&
                 (abs_pull < limit_ff) && rd_ok && !rd_ovl &&
                 ($signed({{(MINMOM_W - MOM_W){1'b0}}, rd_mom}) > minmom_ff);
   end

   // uniqueness of the cell under the scan index
   always_comb begin
      uniq = 1'b1;
      for (int k = 0; k < MAX_ROWS; k++) begin
         row_other[k] = |(pm_ff[k] & ~(MAX_COLS'(1) << cj));
      end
      if (row_other[ci]) begin
         uniq = 1'b0;
      end
      for (int k = 0; k < MAX_ROWS; k++) begin
         if (ROW_W'(k) != ci && pm_ff[k][cj] && !row_other[k]) begin
            uniq = 1'b0;
         end
      end
   end

   assign step_eff = (pull_step_ff == '0) ? CFG_PULL_W'(1) : pull_step_ff;

   always_comb begin
      new_res.row     = ci;
      new_res.col     = cj;
      new_res.pull    = rd_pull;
      new_res.mom     = rd_mom;
      new_res.quality = cmd.quality;
      new_res.is_pair = 1'b1;
      new_res.last    = 1'b0;
   end

   always_comb begin
      pull_start_in = pull_start_ff;
      pull_end_in   = pull_end_ff;
      pull_step_in  = pull_step_ff;
      mom_start_in  = mom_start_ff;
      mom_step_in   = mom_step_ff;
      cons_mode_in  = cons_mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULL_START: pull_start_in = csr_wdata[CFG_PULL_W-1:0];
            CSR_PULL_END:   pull_end_in   = csr_wdata[CFG_PULL_W-1:0];
            CSR_PULL_STEP:  pull_step_in  = csr_wdata[CFG_PULL_W-1:0];
            CSR_MOM_START:  mom_start_in  = csr_wdata;
            CSR_MOM_STEP:   mom_step_in   = csr_wdata;
            CSR_CONS_MODE:  cons_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      limit_in      = limit_ff;
      minmom_in     = minmom_ff;
      pm_in         = pm_ff;
      marks_in      = marks_ff;
      pend_in       = cmd.build_rd;
      pend_addr_in  = cmd.idx;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.load) begin
         marks_in[req_row][req_col] = 1'b0;
      end
      if (cmd.start) begin
         rows_in       = (req_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : req_rows;
         cols_in       = (req_cols > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : req_cols;
         limit_in      = LIMIT_W'(pull_start_ff);
         minmom_in     = MINMOM_W'(mom_start_ff);
         held_valid_in = 1'b0;
      end
      if (cmd.advance) begin
         limit_in  = limit_ff + LIMIT_W'(step_eff);
         minmom_in = minmom_ff + MINMOM_W'(mom_step_ff);
      end
      if (cmd.cons_set) begin
         limit_in = LIMIT_W'(pull_end_ff);
      end
      if (pend_ff) begin
         pm_in[pr][pc] = pass_bit;
      end
      if (cmd.take && !cmd.take_cons) begin
         for (int k = 0; k < MAX_ROWS; k++) begin
            pm_in[k][cj]    = 1'b0;
            marks_in[k][cj] = 1'b1;
         end
      end
      if (cmd.emit) begin
         if (held_valid_ff) begin
            out_in       = held_ff;
            out_valid_in = 1'b1;
         end
         held_in       = new_res;
         held_valid_in = 1'b1;
      end
      if (cmd.flush) begin
         if (held_valid_ff) begin
            out_in      = held_ff;
            out_in.last = 1'b1;
         end else begin
            out_in      = '0;
            out_in.last = 1'b1;
         end
         out_valid_in  = 1'b1;
         held_valid_in = 1'b0;
      end
      if (cmd.clear_marks) begin
         marks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_start_ff <= CFG_PULL_W'(256);
         pull_end_ff   <= CFG_PULL_W'(768);
         pull_step_ff  <= CFG_PULL_W'(128);
         mom_start_ff  <= '0;
         mom_step_ff   <= '0;
         cons_mode_ff  <= 1'b1;
         rows_ff       <= '0;
         cols_ff       <= '0;
         marks_ff      <= '0;
         pend_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pull_start_ff <= pull_start_in;
         pull_end_ff   <= pull_end_in;
         pull_step_ff  <= pull_step_in;
         mom_start_ff  <= mom_start_in;
         mom_step_ff   <= mom_step_in;
         cons_mode_ff  <= cons_mode_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         marks_ff      <= marks_in;
         pend_ff       <= pend_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      minmom_ff    <= minmom_in;
      pm_ff        <= pm_in;
      pend_addr_ff <= pend_addr_in;
      held_ff      <= held_in;
      out_ff       <= out_in;
   end

   always_comb begin
      sts.cell_pass   = pm_ff[ci][cj];
      sts.cell_unique = uniq;
      sts.below_end   = limit_ff < LIMIT_W'(pull_end_ff);
      sts.cons_mode   = cons_mode_ff;
      sts.out_free    = !out_valid_ff || rsp_ready;
      sts.held_valid  = held_valid_ff;
      sts.max_match   = (rows_ff < cols_ff) ? rows_ff : cols_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule

// ===== hdl/unique_track_pair_matcher.sv =====
// top level of the unique track pair matcher
// depends on utpm_pkg, utpm_ifs, utpm_ctrl, utpm_dp and the macros header
//
// usage
// - req channel: one candidate per transfer into an 8 x 8 store at
//   (row_index, col_index); one transfer per cycle while loading
// - the transfer with last_item set also latches rows_in_use / cols_in_use
//   and starts matching; req ready stays low until the final result of the
//   matrix has been loaded into the output register
// - matching runs pull limit rounds; every pass of a round walks the store
//   once to build the pass map and then scans all 64 cells, with a read
//   and an emit step for each emitted pair; the pace is set by the single
//   read port of the store
// - rsp channel: one transfer per emitted pair, last_result on the final
//   one; an empty matrix gives a single transfer with is_pair low
// - one result is held back so the last one can be flagged; a stalled
//   receiver simply pauses the scan, nothing is dropped
// - csr port: write enable, index, data; write only while idle
// - reset (synchronous, active high) restores register defaults and clears
//   the assigned marks; the store content stays undefined until written
`include "unique_track_pair_matcher_macros.svh"
module unique_track_pair_matcher (
   input  logic                            clock,
   input  logic                            reset,
   utpm_req_if.sink                        req_ch,
   utpm_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [utpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [utpm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import utpm_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   result_type rsp_data;
   logic       rsp_valid;
   logic       req_ready;

   // sequencer
   utpm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_last (req_ch.last_item),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // store, pass map and result registers
   utpm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_row  (req_ch.row_index),
      .req_col  (req_ch.col_index),
      .req_pull (req_ch.pull_value),
      .req_mom  (req_ch.momentum_value),
      .req_ok   (req_ch.cluster_ok),
      .req_ovl  (req_ch.overlap_seen),
      .req_rows (req_ch.rows_in_use),
      .req_cols (req_ch.cols_in_use),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.match_row      = rsp_data.row;
   assign rsp_ch.match_col      = rsp_data.col;
   assign rsp_ch.match_pull     = rsp_data.pull;
   assign rsp_ch.match_momentum = rsp_data.mom;
   assign rsp_ch.quality        = rsp_data.quality;
   assign rsp_ch.is_pair        = rsp_data.is_pair;
   assign rsp_ch.last_result    = rsp_data.last;

   // a pair only enters the held slot when the older one can move on
   `UTPM_ASSERT_IMP(a_emit_room, clock, reset, cmd.emit, (!sts.held_valid || sts.out_free))
   // a flush loads the final transfer into the output register
   `UTPM_ASSERT_NEXT(a_flush_out, clock, reset, cmd.flush, (rsp_ch.valid && rsp_ch.last_result))
   // an empty result is always the final one of its matrix
   `UTPM_ASSERT_IMP(a_empty_last, clock, reset, rsp_ch.valid && !rsp_ch.is_pair, rsp_ch.last_result)
   // no new matrix is taken while a result is still held back
   `UTPM_ASSERT_IMP(a_idle_clean, clock, reset, req_ch.ready, !sts.held_valid)
endmodule
